/* hdl/pidaw_pkg.sv */
// Shared types, constants and saturation helpers for the PID controller.
// No dependencies; every other file of the block refers into this package.
package pidaw_pkg;

   localparam int DATA_W    = 32;                // values, gains, limits
   localparam int FRAC_W    = 16;                // fraction bits of Q16.16
   localparam int ISUM_W    = 48;                // integral accumulator
   localparam int ELAPSED_W = 16;
   localparam int CHUNK_W   = 16;                // multiplier B slice per cycle
   localparam int ACC_W     = DATA_W + ISUM_W;   // full gain product
   localparam int QUO_W     = DATA_W + 1;        // derivative difference
   localparam int SUM_W     = 50;                // P + I + D sum
   localparam int WIDE_W    = SUM_W + 1;         // integral update before saturation
   localparam int REG_IDX_W = 3;
   localparam int DIV_CNT_W = 6;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

   localparam logic signed [DATA_W-1:0] LIMIT_HIGH_RESET = 32'sh0064_0000;

   localparam logic signed [ISUM_W-1:0] ISUM_MAX = {1'b0, {(ISUM_W-1){1'b1}}};
   localparam logic signed [ISUM_W-1:0] ISUM_MIN = {1'b1, {(ISUM_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // magnitude caps of a saturated gain product
   localparam logic [ISUM_W-1:0] CAP_POS = {1'b0, {(ISUM_W-1){1'b1}}};
   localparam logic [ISUM_W-1:0] CAP_NEG = {1'b1, {(ISUM_W-1){1'b0}}};

   typedef enum logic [REG_IDX_W-1:0] {
      REG_GAIN_P           = 3'd0,
      REG_GAIN_I           = 3'd1,
      REG_GAIN_D           = 3'd2,
      REG_TARGET           = 3'd3,
      REG_LIMIT_LOW        = 3'd4,
      REG_LIMIT_HIGH       = 3'd5,
      REG_DERIV_ON_MEASURE = 3'd6
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERROR,
      ST_BRANCH,
      ST_MUL,
      ST_DIVIDE,
      ST_SUM,
      ST_CLAMP,
      ST_BACKOFF,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      OP_SCALE,   // |error| * elapsed, raw product
      OP_INTEG,   // gain_i term
      OP_DERIV,   // gain_d term
      OP_PROP     // gain_p term
   } mul_op_type;

   typedef struct packed {
      logic       start;
      logic       neg;
      logic [1:0] last_chunk;
   } mul_ctl_type;

   function automatic logic signed [ISUM_W-1:0] sat_isum(input logic signed [WIDE_W-1:0] x);
      logic [WIDE_W-ISUM_W:0] top;
      top = x[WIDE_W-1:ISUM_W-1];
      if (top == '0 || top == '1) begin
         return x[ISUM_W-1:0];
      end
      return x[WIDE_W-1] ? ISUM_MIN : ISUM_MAX;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [DATA_W:0] x);
      if (x[DATA_W] == x[DATA_W-1]) begin
         return x[DATA_W-1:0];
      end
      return x[DATA_W] ? DATA_MIN : DATA_MAX;
   endfunction

endpackage

/* hdl/pidaw_gain_mul.sv */
// Shared multiplier: 32 x 16 bits per cycle over up to three slices of B,
// with the Q16.16 shift and 48-bit saturation of a signed gain product.
// Depends on pidaw_pkg.
module pidaw_gain_mul (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pidaw_pkg::mul_ctl_type               ctl,
   input  logic [pidaw_pkg::DATA_W-1:0]         op_a,
   input  logic [pidaw_pkg::ISUM_W-1:0]         op_b,
   output logic                                 done,
   output logic [pidaw_pkg::ISUM_W-1:0]         raw_product,
   output logic signed [pidaw_pkg::ISUM_W-1:0]  gain_result
);

   logic                                  busy_ff;
   logic                                  done_ff;
   logic [1:0]                            chunk_ff;
   logic [1:0]                            last_ff;
   logic                                  neg_ff;
   logic [pidaw_pkg::DATA_W-1:0]          a_ff;
   logic [pidaw_pkg::ISUM_W-1:0]          b_ff;
   logic [pidaw_pkg::ACC_W-1:0]           acc_ff;
   logic [pidaw_pkg::ACC_W-1:0]           acc_in;

   logic [pidaw_pkg::CHUNK_W-1:0]         slice;
   logic [pidaw_pkg::DATA_W+pidaw_pkg::CHUNK_W-1:0] partial;
   logic                                  over;
   logic [pidaw_pkg::ISUM_W-1:0]          mag;
   logic [pidaw_pkg::ISUM_W-1:0]          cap;
   logic [pidaw_pkg::ISUM_W-1:0]          sat_mag;
   logic                                  last_step;

   assign last_step = busy_ff && (chunk_ff == last_ff);

   always_comb begin
      case (chunk_ff)
         2'd0:    slice = b_ff[pidaw_pkg::CHUNK_W-1:0];
         2'd1:    slice = b_ff[2*pidaw_pkg::CHUNK_W-1:pidaw_pkg::CHUNK_W];
         default: slice = b_ff[3*pidaw_pkg::CHUNK_W-1:2*pidaw_pkg::CHUNK_W];
      endcase
      partial = a_ff * slice;
      case (chunk_ff)
         2'd0:    acc_in = acc_ff + {{(pidaw_pkg::ACC_W-48){1'b0}}, partial};
         2'd1:    acc_in = acc_ff + {{(pidaw_pkg::ACC_W-64){1'b0}}, partial,
                                     {pidaw_pkg::CHUNK_W{1'b0}}};
         default: acc_in = acc_ff + {partial, {(2*pidaw_pkg::CHUNK_W){1'b0}}};
      endcase
   end

   // drop the fraction, then clip the magnitude to the 48-bit signed range
   always_comb begin
      over    = |acc_ff[pidaw_pkg::ACC_W-1:pidaw_pkg::FRAC_W+pidaw_pkg::ISUM_W];
      mag     = acc_ff[pidaw_pkg::FRAC_W+pidaw_pkg::ISUM_W-1:pidaw_pkg::FRAC_W];
      cap     = neg_ff ? pidaw_pkg::CAP_NEG : pidaw_pkg::CAP_POS;
      sat_mag = (over || mag > cap) ? cap : mag;
   end

   assign gain_result = $signed(neg_ff ? (~sat_mag + 1'b1) : sat_mag);
   assign raw_product = acc_ff[pidaw_pkg::ISUM_W-1:0];
   assign done        = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         chunk_ff <= 2'd0;
      end else begin
         done_ff <= last_step;
         if (ctl.start) begin
            busy_ff  <= 1'b1;
            chunk_ff <= 2'd0;
         end else if (busy_ff) begin
            chunk_ff <= chunk_ff + 2'd1;
            if (last_step) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         a_ff    <= op_a;
         b_ff    <= op_b;
         neg_ff  <= ctl.neg;
         last_ff <= ctl.last_chunk;
         acc_ff  <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
      end
   end

endmodule

/* hdl/pidaw_divider.sv */
// Restoring divider, one quotient bit per cycle: 33-bit magnitude by
// 16-bit elapsed count, truncating. Depends on pidaw_pkg.
module pidaw_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [pidaw_pkg::QUO_W-1:0]        dividend,
   input  logic [pidaw_pkg::ELAPSED_W-1:0]    divisor,
   output logic                               done,
   output logic [pidaw_pkg::QUO_W-1:0]        quotient
);

   logic                                 busy_ff;
   logic                                 done_ff;
   logic [pidaw_pkg::DIV_CNT_W-1:0]      count_ff;
   logic [pidaw_pkg::QUO_W-1:0]          quo_ff;
   logic [pidaw_pkg::QUO_W-1:0]          quo_in;
   logic [pidaw_pkg::ELAPSED_W-1:0]      rem_ff;
   logic [pidaw_pkg::ELAPSED_W-1:0]      rem_in;
   logic [pidaw_pkg::ELAPSED_W-1:0]      dvs_ff;

   logic [pidaw_pkg::ELAPSED_W:0]        trial;
   logic [pidaw_pkg::ELAPSED_W:0]        trial_sub;
   logic                                 fits;
   logic                                 last_step;

   assign last_step = busy_ff && (count_ff == pidaw_pkg::DIV_LAST);

   always_comb begin
      trial     = {rem_ff, quo_ff[pidaw_pkg::QUO_W-1]};
      trial_sub = trial - {1'b0, dvs_ff};
      fits      = (trial >= {1'b0, dvs_ff});
      rem_in    = fits ? trial_sub[pidaw_pkg::ELAPSED_W-1:0]
                       : trial[pidaw_pkg::ELAPSED_W-1:0];
      quo_in    = {quo_ff[pidaw_pkg::QUO_W-2:0], fits};
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= last_step;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (last_step) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

endmodule

/* hdl/pid_controller_antiwindup.sv */
// PID controller with integral back-off, Q16.16. One word in, one word out.
// A sample with nonzero elapsed runs the 33-step divider and the 9 slices through
// the shared 32x16 multiplier; zero elapsed runs only the 2-slice proportional
// product, and a clear or first sample skips both; output stalls hold it in emit.
// One sample in flight; req_stall holds until its word is loaded, so no new sample
// is taken before then. Reset restores defaults, empties history.
module pid_controller_antiwindup (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_func,
   input  logic signed [pidaw_pkg::DATA_W-1:0]     req_measurement,
   input  logic [pidaw_pkg::ELAPSED_W-1:0]         req_elapsed,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [pidaw_pkg::DATA_W-1:0]     rsp_drive,
   output logic                                    rsp_clamped,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [pidaw_pkg::REG_IDX_W-1:0]         csr_index,
   input  logic [pidaw_pkg::DATA_W-1:0]            csr_wdata
);

   localparam int DW = pidaw_pkg::DATA_W;
   localparam int IW = pidaw_pkg::ISUM_W;
   localparam int SW = pidaw_pkg::SUM_W;
   localparam int WW = pidaw_pkg::WIDE_W;

   // configuration registers
   logic [DW-1:0]         gain_p_ff;
   logic [DW-1:0]         gain_i_ff;
   logic [DW-1:0]         gain_d_ff;
   logic signed [DW-1:0]  target_ff;
   logic signed [DW-1:0]  limit_low_ff;
   logic signed [DW-1:0]  limit_high_ff;
   logic                  deriv_meas_ff;

   pidaw_pkg::state_type  state_ff, state_in;
   pidaw_pkg::mul_op_type op_ff, op_in;

   logic                  func_ff, func_in;
   logic signed [DW-1:0]  meas_ff, meas_in;
   logic [pidaw_pkg::ELAPSED_W-1:0] dt_ff, dt_in;
   logic signed [DW-1:0]  err_ff, err_in;
   logic signed [IW-1:0]  integ_ff, integ_in;
   logic signed [DW-1:0]  prev_err_ff, prev_err_in;
   logic signed [DW-1:0]  prev_meas_ff, prev_meas_in;
   logic                  primed_ff, primed_in;
   logic                  dneg_ff, dneg_in;
   logic signed [SW-1:0]  dterm_ff, dterm_in;
   logic signed [SW-1:0]  pid_ff, pid_in;
   logic signed [SW-1:0]  sum_ff, sum_in;
   logic signed [SW-1:0]  excess_ff, excess_in;
   logic                  clip_ff, clip_in;
   logic                  lower_ff, lower_in;
   logic signed [DW-1:0]  drive_ff, drive_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]  rsp_drive_ff, rsp_drive_in;
   logic                  rsp_clamped_ff, rsp_clamped_in;
   logic                  rsp_load;

   // shared units
   pidaw_pkg::mul_ctl_type       mul_ctl;
   logic [DW-1:0]                mul_a;
   logic [IW-1:0]                mul_b;
   logic                         mul_done;
   logic [IW-1:0]                mul_raw;
   logic signed [IW-1:0]         mul_result;
   logic                         div_start;
   logic [pidaw_pkg::QUO_W-1:0]  div_dividend;
   logic                         div_done;
   logic [pidaw_pkg::QUO_W-1:0]  div_quotient;

   // datapath helpers
   logic signed [DW:0]    err_wide;
   logic [DW-1:0]         err_mag;
   logic signed [DW:0]    diff;
   logic [DW:0]           diff_mag;
   logic signed [SW-1:0]  gres_ext;
   logic signed [SW-1:0]  integ_ext;
   logic signed [SW-1:0]  high_ext;
   logic signed [SW-1:0]  low_ext;
   logic signed [WW-1:0]  integ_wide;
   logic signed [WW-1:0]  gres_wide;
   logic signed [WW-1:0]  excess_wide;
   logic                  csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_stall = (state_ff != pidaw_pkg::ST_IDLE);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = rsp_drive_ff;
   assign rsp_clamped = rsp_clamped_ff;

   pidaw_gain_mul u_mul (
      .clock       (clock),
      .reset       (reset),
      .ctl         (mul_ctl),
      .op_a        (mul_a),
      .op_b        (mul_b),
      .done        (mul_done),
      .raw_product (mul_raw),
      .gain_result (mul_result)
   );

   pidaw_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (dt_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      err_wide = $signed({target_ff[DW-1], target_ff}) - $signed({meas_ff[DW-1], meas_ff});
      err_mag  = err_ff[DW-1] ? (~err_ff + 1'b1) : err_ff;
      if (deriv_meas_ff) begin
         diff = $signed({meas_ff[DW-1], meas_ff})
              - $signed({prev_meas_ff[DW-1], prev_meas_ff});
      end else begin
         diff = $signed({err_ff[DW-1], err_ff})
              - $signed({prev_err_ff[DW-1], prev_err_ff});
      end
      diff_mag    = diff[DW] ? (~diff + 1'b1) : diff;
      gres_ext    = $signed({{(SW-IW){mul_result[IW-1]}}, mul_result});
      integ_ext   = $signed({{(SW-IW){integ_ff[IW-1]}}, integ_ff});
      high_ext    = $signed({{(SW-DW){limit_high_ff[DW-1]}}, limit_high_ff});
      low_ext     = $signed({{(SW-DW){limit_low_ff[DW-1]}}, limit_low_ff});
      integ_wide  = $signed({{(WW-IW){integ_ff[IW-1]}}, integ_ff});
      gres_wide   = $signed({{(WW-IW){mul_result[IW-1]}}, mul_result});
      excess_wide = $signed({excess_ff[SW-1], excess_ff});
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      func_in      = func_ff;
      meas_in      = meas_ff;
      dt_in        = dt_ff;
      err_in       = err_ff;
      integ_in     = integ_ff;
      prev_err_in  = prev_err_ff;
      prev_meas_in = prev_meas_ff;
      primed_in    = primed_ff;
      dneg_in      = dneg_ff;
      dterm_in     = dterm_ff;
      pid_in       = pid_ff;
      sum_in       = sum_ff;
      excess_in    = excess_ff;
      clip_in      = clip_ff;
      lower_in     = lower_ff;
      drive_in     = drive_ff;
      mul_ctl      = '0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      rsp_load     = 1'b0;

      case (state_ff)
         pidaw_pkg::ST_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               meas_in  = req_measurement;
               dt_in    = req_elapsed;
               state_in = pidaw_pkg::ST_ERROR;
            end
         end

         pidaw_pkg::ST_ERROR: begin
            err_in   = pidaw_pkg::sat_data(err_wide);
            state_in = pidaw_pkg::ST_BRANCH;
         end

         pidaw_pkg::ST_BRANCH: begin
            if (func_ff) begin
               integ_in     = '0;
               prev_err_in  = '0;
               prev_meas_in = '0;
               primed_in    = 1'b0;
               clip_in      = 1'b0;
               drive_in     = '0;
               state_in     = pidaw_pkg::ST_EMIT;
            end else if (!primed_ff) begin
               // record history only
               prev_err_in  = err_ff;
               prev_meas_in = meas_ff;
               primed_in    = 1'b1;
               clip_in      = 1'b0;
               drive_in     = '0;
               state_in     = pidaw_pkg::ST_EMIT;
            end else if (dt_ff == '0) begin
               dterm_in           = '0;
               op_in              = pidaw_pkg::OP_PROP;
               mul_ctl.start      = 1'b1;
               mul_ctl.neg        = err_ff[DW-1];
               mul_ctl.last_chunk = 2'd1;
               mul_a              = gain_p_ff;
               mul_b              = {{(IW-DW){1'b0}}, err_mag};
               state_in           = pidaw_pkg::ST_MUL;
            end else begin
               op_in              = pidaw_pkg::OP_SCALE;
               mul_ctl.start      = 1'b1;
               mul_ctl.last_chunk = 2'd0;
               mul_a              = err_mag;
               mul_b              = {{(IW-pidaw_pkg::ELAPSED_W){1'b0}}, dt_ff};
               state_in           = pidaw_pkg::ST_MUL;
            end
         end

         pidaw_pkg::ST_MUL: begin
            if (mul_done) begin
               case (op_ff)
                  pidaw_pkg::OP_SCALE: begin
                     op_in              = pidaw_pkg::OP_INTEG;
                     mul_ctl.start      = 1'b1;
                     mul_ctl.neg        = err_ff[DW-1];
                     mul_ctl.last_chunk = 2'd2;
                     mul_a              = gain_i_ff;
                     mul_b              = mul_raw;
                  end
                  pidaw_pkg::OP_INTEG: begin
                     integ_in     = pidaw_pkg::sat_isum(integ_wide + gres_wide);
                     dneg_in      = diff[DW];
                     div_start    = 1'b1;
                     div_dividend = diff_mag;
                     state_in     = pidaw_pkg::ST_DIVIDE;
                  end
                  pidaw_pkg::OP_DERIV: begin
                     dterm_in           = deriv_meas_ff ? -gres_ext : gres_ext;
                     op_in              = pidaw_pkg::OP_PROP;
                     mul_ctl.start      = 1'b1;
                     mul_ctl.neg        = err_ff[DW-1];
                     mul_ctl.last_chunk = 2'd1;
                     mul_a              = gain_p_ff;
                     mul_b              = {{(IW-DW){1'b0}}, err_mag};
                  end
                  default: begin
                     pid_in   = gres_ext + dterm_ff;
                     state_in = pidaw_pkg::ST_SUM;
                  end
               endcase
            end
         end

         pidaw_pkg::ST_DIVIDE: begin
            if (div_done) begin
               op_in              = pidaw_pkg::OP_DERIV;
               mul_ctl.start      = 1'b1;
               mul_ctl.neg        = dneg_ff;
               mul_ctl.last_chunk = 2'd2;
               mul_a              = gain_d_ff;
               mul_b              = {{(IW-pidaw_pkg::QUO_W){1'b0}}, div_quotient};
               state_in           = pidaw_pkg::ST_MUL;
            end
         end

         pidaw_pkg::ST_SUM: begin
            sum_in   = pid_ff + integ_ext;
            state_in = pidaw_pkg::ST_CLAMP;
         end

         pidaw_pkg::ST_CLAMP: begin
            // upper limit is tested first, also when the limits cross
            if (sum_ff > high_ext) begin
               excess_in = sum_ff - high_ext;
               lower_in  = 1'b0;
               clip_in   = 1'b1;
               drive_in  = limit_high_ff;
            end else if (sum_ff < low_ext) begin
               excess_in = low_ext - sum_ff;
               lower_in  = 1'b1;
               clip_in   = 1'b1;
               drive_in  = limit_low_ff;
            end else begin
               excess_in = '0;
               lower_in  = 1'b0;
               clip_in   = 1'b0;
               drive_in  = sum_ff[DW-1:0];
            end
            state_in = pidaw_pkg::ST_BACKOFF;
         end

         pidaw_pkg::ST_BACKOFF: begin
            if (clip_ff) begin
               integ_in = lower_ff ? pidaw_pkg::sat_isum(integ_wide + excess_wide)
                                   : pidaw_pkg::sat_isum(integ_wide - excess_wide);
            end
            prev_err_in  = err_ff;
            prev_meas_in = meas_ff;
            state_in     = pidaw_pkg::ST_EMIT;
         end

         pidaw_pkg::ST_EMIT: begin
            // hold until the output register is free or being taken
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = pidaw_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pidaw_pkg::ST_IDLE;
         end
      endcase

      // a zero integral gain empties the integral
      if (csr_write && csr_index == pidaw_pkg::REG_GAIN_I && csr_wdata == '0) begin
         integ_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_drive_in   = rsp_load ? drive_ff : rsp_drive_ff;
      rsp_clamped_in = rsp_load ? clip_ff : rsp_clamped_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pidaw_pkg::ST_IDLE;
         op_ff        <= pidaw_pkg::OP_SCALE;
         integ_ff     <= '0;
         prev_err_ff  <= '0;
         prev_meas_ff <= '0;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         integ_ff     <= integ_in;
         prev_err_ff  <= prev_err_in;
         prev_meas_ff <= prev_meas_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      meas_ff        <= meas_in;
      dt_ff          <= dt_in;
      err_ff         <= err_in;
      dneg_ff        <= dneg_in;
      dterm_ff       <= dterm_in;
      pid_ff         <= pid_in;
      sum_ff         <= sum_in;
      excess_ff      <= excess_in;
      clip_ff        <= clip_in;
      lower_ff       <= lower_in;
      drive_ff       <= drive_in;
      rsp_drive_ff   <= rsp_drive_in;
      rsp_clamped_ff <= rsp_clamped_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         target_ff     <= '0;
         limit_low_ff  <= '0;
         limit_high_ff <= pidaw_pkg::LIMIT_HIGH_RESET;
         deriv_meas_ff <= 1'b1;
      end else if (csr_write) begin
         case (pidaw_pkg::reg_index_type'(csr_index))
            pidaw_pkg::REG_GAIN_P:           gain_p_ff     <= csr_wdata;
            pidaw_pkg::REG_GAIN_I:           gain_i_ff     <= csr_wdata;
            pidaw_pkg::REG_GAIN_D:           gain_d_ff     <= csr_wdata;
            pidaw_pkg::REG_TARGET:           target_ff     <= $signed(csr_wdata);
            pidaw_pkg::REG_LIMIT_LOW:        limit_low_ff  <= $signed(csr_wdata);
            pidaw_pkg::REG_LIMIT_HIGH:       limit_high_ff <= $signed(csr_wdata);
            pidaw_pkg::REG_DERIV_ON_MEASURE: deriv_meas_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // the shared units only report completion to the state that waits on them
   assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == pidaw_pkg::ST_MUL)
      else $error("multiplier finished outside the multiply state");

   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == pidaw_pkg::ST_DIVIDE)
      else $error("divider finished outside the divide state");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == pidaw_pkg::ST_EMIT)
      else $error("result word appeared without passing the emit state");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == pidaw_pkg::ST_SUM |-> primed_ff && !func_ff)
      else $error("full PID sum formed for a clear or first sample");

endmodule

/* sim/pidaw_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for pid_controller_antiwindup: watches the register, sample and result
// channels, predicts every drive word and compares it. Depends on pidaw_pkg.
module pidaw_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_func,
   input  logic signed [pidaw_pkg::DATA_W-1:0] req_measurement,
   input  logic [pidaw_pkg::ELAPSED_W-1:0]     req_elapsed,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [pidaw_pkg::DATA_W-1:0] rsp_drive,
   input  logic                                rsp_clamped,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [pidaw_pkg::REG_IDX_W-1:0]     csr_index,
   input  logic [pidaw_pkg::DATA_W-1:0]        csr_wdata,
   output int                                  fail_count,
   output int                                  pending,
   output int                                  results_seen,
   output int                                  clamped_seen
);

   localparam int DW = pidaw_pkg::DATA_W;
   localparam int FW = pidaw_pkg::FRAC_W;
   localparam int IW = pidaw_pkg::ISUM_W;

   logic [DW-1:0]            k_prop;
   logic [DW-1:0]            k_integ;
   logic [DW-1:0]            k_deriv;
   longint                   setpoint;
   longint                   clamp_lo;
   longint                   clamp_hi;
   logic                     d_on_meas;
   longint                   integ;
   longint                   last_err;
   longint                   last_meas;
   logic                     primed;
   logic signed [DW-1:0]     drive_due[$];
   logic                     clamp_due[$];
   int                       fails;
   int                       seen;
   int                       clamps;

   function automatic longint clip_to(input longint x, input int bits);
      longint top;
      top = (longint'(1) << (bits - 1)) - 1;
      if (x > top) begin
         return top;
      end
      if (x < -top - 1) begin
         return -top - 1;
      end
      return x;
   endfunction

   // gain * operand >> FW, magnitude truncated, capped to the integral range
   function automatic longint gain_product(input logic [DW-1:0] gain,
                                           input longint operand);
      logic [127:0] mag;
      logic [127:0] prod;
      logic [127:0] cap;
      logic         neg;
      neg  = operand < 0;
      mag  = neg ? 128'(-operand) : 128'(operand);
      prod = (128'(gain) * mag) >> FW;
      cap  = neg ? (128'(1) << (IW - 1)) : (128'(1) << (IW - 1)) - 1;
      if (prod > cap) begin
         prod = cap;
      end
      return neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
   endfunction

   task automatic apply_setting(input logic [pidaw_pkg::REG_IDX_W-1:0] idx,
                                input logic [DW-1:0] value);
      case (idx)
         pidaw_pkg::REG_GAIN_P: k_prop = value;
         pidaw_pkg::REG_GAIN_I: begin
            k_integ = value;
            if (value == '0) begin
               integ = 0;
            end
         end
         pidaw_pkg::REG_GAIN_D:           k_deriv = value;
         pidaw_pkg::REG_TARGET:           setpoint = $signed(value);
         pidaw_pkg::REG_LIMIT_LOW:        clamp_lo = $signed(value);
         pidaw_pkg::REG_LIMIT_HIGH:       clamp_hi = $signed(value);
         pidaw_pkg::REG_DERIV_ON_MEASURE: d_on_meas = value[0];
         default: ;
      endcase
   endtask

   task automatic predict_drive(input logic func, input longint meas, input longint span);
      longint err;
      longint dterm;
      longint total;
      logic   limited;
      dterm   = 0;
      limited = 1'b0;
      err     = clip_to(setpoint - meas, DW);
      if (func) begin
         integ     = 0;
         last_err  = 0;
         last_meas = 0;
         primed    = 1'b0;
         drive_due.push_back('0);
         clamp_due.push_back(1'b0);
      end else if (!primed) begin
         // first sample only records history
         last_err  = err;
         last_meas = meas;
         primed    = 1'b1;
         drive_due.push_back('0);
         clamp_due.push_back(1'b0);
      end else begin
         if (span != 0) begin
            integ = clip_to(integ + gain_product(k_integ, err * span), IW);
            if (d_on_meas) begin
               dterm = -gain_product(k_deriv, (meas - last_meas) / span);
            end else begin
               dterm = gain_product(k_deriv, (err - last_err) / span);
            end
         end
         total = gain_product(k_prop, err) + integ + dterm;
         // upper test first, so crossed limits fall to the low side otherwise
         if (total > clamp_hi) begin
            integ   = clip_to(integ - (total - clamp_hi), IW);
            total   = clamp_hi;
            limited = 1'b1;
         end else if (total < clamp_lo) begin
            integ   = clip_to(integ + (clamp_lo - total), IW);
            total   = clamp_lo;
            limited = 1'b1;
         end
         last_err  = err;
         last_meas = meas;
         drive_due.push_back(DW'(total));
         clamp_due.push_back(limited);
      end
   endtask

   task automatic check_drive();
      logic signed [DW-1:0] want_drive;
      logic                 want_clamp;
      seen++;
      if (rsp_clamped) begin
         clamps++;
      end
      if (drive_due.size() == 0) begin
         $display("%0t: unexpected word: expected none, got drive %0d clamped %0b",
                  $time, rsp_drive, rsp_clamped);
         fails++;
      end else begin
         want_drive = drive_due.pop_front();
         want_clamp = clamp_due.pop_front();
         if (rsp_drive !== want_drive) begin
            $display("%0t: drive expected %0d got %0d", $time, want_drive, rsp_drive);
            fails++;
         end
         if (rsp_clamped !== want_clamp) begin
            $display("%0t: clamped expected %0b got %0b", $time, want_clamp, rsp_clamped);
            fails++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         k_prop    = '0;
         k_integ   = '0;
         k_deriv   = '0;
         setpoint  = 0;
         clamp_lo  = 0;
         clamp_hi  = pidaw_pkg::LIMIT_HIGH_RESET;
         d_on_meas = 1'b1;
         integ     = 0;
         last_err  = 0;
         last_meas = 0;
         primed    = 1'b0;
         drive_due.delete();
         clamp_due.delete();
         fails     = 0;
         seen      = 0;
         clamps    = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            apply_setting(csr_index, csr_wdata);
         end
         if (req_valid && !req_stall) begin
            predict_drive(req_func, req_measurement, req_elapsed);
         end
         if (rsp_valid && !rsp_stall) begin
            check_drive();
         end
      end
      fail_count   <= fails;
      pending      <= drive_due.size();
      results_seen <= seen;
      clamped_seen <= clamps;
   end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Top of the PID controller bench: clock, reset, register setup and sample stimulus.
// Depends on pidaw_pkg, pid_controller_antiwindup and pidaw_checker.
module testbench;

   localparam int DW = pidaw_pkg::DATA_W;
   localparam int EW = pidaw_pkg::ELAPSED_W;
   localparam int FW = pidaw_pkg::FRAC_W;
   localparam logic signed [DW-1:0] ONE = 32'sh0001_0000;
   localparam int DRAIN_CYCLES = 60;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 200;

   logic                     clock           = 1'b0;
   logic                     reset           = 1'b1;
   logic                     req_valid       = 1'b0;
   logic                     req_func        = 1'b0;
   logic signed [DW-1:0]     req_measurement = '0;
   logic [EW-1:0]            req_elapsed     = '0;
   logic                     rsp_stall       = 1'b0;
   logic                     csr_valid       = 1'b0;
   logic [pidaw_pkg::REG_IDX_W-1:0] csr_index = '0;
   logic [DW-1:0]            csr_wdata       = '0;
   logic                     req_stall;
   logic                     rsp_valid;
   logic signed [DW-1:0]     rsp_drive;
   logic                     rsp_clamped;
   logic                     csr_ready;

   int                       fail_count;
   int                       pending;
   int                       results_seen;
   int                       clamped_seen;

   int                       send_gap_pct = 33;
   int                       recv_gap_pct = 45;
   int                       samples_sent = 0;
   int                       clears_sent  = 0;
   int                       settings_loaded = 0;
   logic signed [DW-1:0]     setpoint_now = '0;
   int                       hold_left = 0;
   logic                     hold_done = 1'b0;

   pid_controller_antiwindup i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_measurement (req_measurement),
      .req_elapsed     (req_elapsed),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_drive       (rsp_drive),
      .rsp_clamped     (rsp_clamped),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   pidaw_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_measurement (req_measurement),
      .req_elapsed     (req_elapsed),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_drive       (rsp_drive),
      .rsp_clamped     (rsp_clamped),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_seen    (results_seen),
      .clamped_seen    (clamped_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stalls, plus one long hold-off once traffic is flowing
   always @(posedge clock) begin
      if (!hold_done && results_seen >= 300) begin
         hold_done = 1'b1;
         hold_left = 600;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_gap_pct);
      end
   end

   initial begin
      #10_000_000;
      $display("pid_controller_antiwindup: mismatch");
      $finish;
   end

   function automatic logic [DW-1:0] corner_word(input logic [DW-1:0] lowest,
                                                 input logic [DW-1:0] highest);
      case ($urandom_range(2))
         0:       return lowest;
         1:       return highest;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(input logic func, input logic signed [DW-1:0] meas,
                            input logic [EW-1:0] span);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_gap_pct) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_measurement <= meas;
      req_elapsed     <= span;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (func) begin
         clears_sent++;
      end else begin
         samples_sent++;
      end
   endtask

   task automatic write_reg(input pidaw_pkg::reg_index_type idx, input logic [DW-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // drop valid, wait for every outstanding word, then let the block go idle
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input logic [DW-1:0] kp, input logic [DW-1:0] ki,
                                input logic [DW-1:0] kd,
                                input logic signed [DW-1:0] sp,
                                input logic signed [DW-1:0] lo,
                                input logic signed [DW-1:0] hi, input logic dom);
      write_reg(pidaw_pkg::REG_GAIN_P, kp);
      write_reg(pidaw_pkg::REG_GAIN_I, ki);
      write_reg(pidaw_pkg::REG_GAIN_D, kd);
      write_reg(pidaw_pkg::REG_TARGET, sp);
      write_reg(pidaw_pkg::REG_LIMIT_LOW, lo);
      write_reg(pidaw_pkg::REG_LIMIT_HIGH, hi);
      write_reg(pidaw_pkg::REG_DERIV_ON_MEASURE, DW'(dom));
      csr_valid <= 1'b0;
      setpoint_now = sp;
      settings_loaded++;
   endtask

   // even phases: moderate gains and limits; odd phases: extremes, limits may cross
   task automatic random_settings(input int phase);
      logic [DW-1:0]        kp;
      logic [DW-1:0]        ki;
      logic [DW-1:0]        kd;
      logic signed [DW-1:0] sp;
      logic signed [DW-1:0] lo;
      logic signed [DW-1:0] hi;
      if (phase % 2 == 0) begin
         kp = $urandom_range(0, 32'h0004_0000);
         ki = ($urandom_range(3) == 0) ? '0 : $urandom_range(0, 32'h0002_0000);
         kd = $urandom_range(0, 32'h0004_0000);
         sp = $signed($urandom_range(0, 400 << FW)) - (200 << FW);
         lo = -$signed($urandom_range(0, 100 << FW));
         hi = $signed($urandom_range(0, 100 << FW));
      end else begin
         kp = corner_word('0, '1);
         ki = corner_word('0, '1);
         kd = corner_word('0, '1);
         sp = corner_word(pidaw_pkg::DATA_MIN, pidaw_pkg::DATA_MAX);
         lo = corner_word(pidaw_pkg::DATA_MIN, pidaw_pkg::DATA_MAX);
         hi = corner_word(pidaw_pkg::DATA_MIN, pidaw_pkg::DATA_MAX);
      end
      load_settings(kp, ki, kd, sp, lo, hi, 1'($urandom_range(1)));
   endtask

   task automatic random_item();
      logic                 func;
      logic signed [DW-1:0] meas;
      logic [EW-1:0]        span;
      func = ($urandom_range(99) < 4);
      case ($urandom_range(9))
         0:       meas = $urandom;
         1:       meas = corner_word(pidaw_pkg::DATA_MIN, pidaw_pkg::DATA_MAX);
         default: meas = setpoint_now + $signed($urandom_range(0, 100 << FW))
                         - (50 << FW);
      endcase
      case ($urandom_range(9))
         0:       span = '0;
         1:       span = EW'($urandom);
         2:       span = '1;
         default: span = EW'($urandom_range(1, 8));
      endcase
      send_word(func, meas, span);
   endtask

   initial begin : stimulus
      int phase;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: first sample, zero elapsed, error saturation, clamps, clear
      load_settings(ONE, ONE / 2, ONE / 4, 10 * ONE, -100 * ONE, 100 * ONE, 1'b1);
      send_word(1'b0, '0, 16'd1);
      send_word(1'b0, 4 * ONE, 16'd1);
      send_word(1'b0, 6 * ONE, 16'd0);
      send_word(1'b0, pidaw_pkg::DATA_MAX, '1);
      send_word(1'b0, pidaw_pkg::DATA_MIN, 16'd1);
      send_word(1'b0, 10 * ONE, 16'd3);
      send_word(1'b1, '1, '1);
      send_word(1'b0, 9 * ONE, 16'd2);
      send_word(1'b0, -5 * ONE, '1);
      send_word(1'b0, 12 * ONE, 16'd1);
      settle();

      // full gains, derivative on error, crossed limits, integral saturation
      load_settings('1, '1, '1, '0, 50 * ONE, -50 * ONE, 1'b0);
      send_word(1'b0, ONE, 16'd1);
      send_word(1'b0, -3 * ONE, 16'd2);
      send_word(1'b0, 3 * ONE, 16'd1);
      send_word(1'b0, pidaw_pkg::DATA_MIN, '1);
      send_word(1'b0, pidaw_pkg::DATA_MAX, '1);
      send_word(1'b0, '0, 16'd0);
      send_word(1'b1, '0, '0);
      send_word(1'b0, '0, 16'd1);
      send_word(1'b0, '0, 16'd1);
      settle();
      write_reg(pidaw_pkg::REG_GAIN_I, '0);
      csr_valid <= 1'b0;
      send_word(1'b0, 2 * ONE, 16'd1);
      settle();

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase < 2) begin
            send_gap_pct = 33;
            recv_gap_pct = 45;
         end else if (phase < 4) begin
            send_gap_pct = 45;
            recv_gap_pct = 33;
         end else begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
         random_settings(phase);
         repeat (PHASE_ITEMS) random_item();
         settle();
      end

      $display("covered %0d samples and %0d clears over %0d register settings,",
               samples_sent, clears_sent, settings_loaded);
      $display("with gaps on both sides and one long output hold: %0d results, %0d clamped",
               results_seen, clamped_seen);
      if (fail_count == 0) begin
         $display("pid_controller_antiwindup: match");
      end else begin
         $display("pid_controller_antiwindup: mismatch");
      end
      $finish;
   end

endmodule
